### design/uvs_pkg.sv
`default_nettype none

package uvs_pkg;

	localparam int unsigned SEG_W        = 9;
	localparam int unsigned MAX_SEGMENTS = 256;
	localparam int unsigned FRAC_BITS    = 14;
	localparam int unsigned PHASE_W      = 32;

	// long division: 48-bit numerator, divisor up to 512, 8 quotient bits per stage
	localparam int unsigned DIV_W      = 48;
	localparam int unsigned REM_W      = 10;
	localparam int unsigned DIV_BITS   = 8;
	localparam int unsigned DIV_STAGES = DIV_W / DIV_BITS;

	localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic [29:0] QUAD_HALF   = 30'h2000_0000;

	// Horner steps; divide by small constants through rounded-up reciprocals
	localparam int unsigned SIN_STEPS = 5;
	localparam int unsigned COS_STEPS = 6;

	localparam logic [31:0] SIN_RCP [SIN_STEPS] = '{
		32'(((64'd1 << 37) + 64'd109) / 64'd110),
		32'(((64'd1 << 37) + 64'd71) / 64'd72),
		32'(((64'd1 << 36) + 64'd41) / 64'd42),
		32'(((64'd1 << 35) + 64'd19) / 64'd20),
		32'(((64'd1 << 33) + 64'd5) / 64'd6)
	};
	localparam int unsigned SIN_SH [SIN_STEPS] = '{37, 37, 36, 35, 33};

	localparam logic [31:0] COS_RCP [COS_STEPS] = '{
		32'(((64'd1 << 38) + 64'd131) / 64'd132),
		32'(((64'd1 << 37) + 64'd89) / 64'd90),
		32'(((64'd1 << 36) + 64'd55) / 64'd56),
		32'(((64'd1 << 35) + 64'd29) / 64'd30),
		32'(((64'd1 << 34) + 64'd11) / 64'd12),
		32'(((64'd1 << 31) + 64'd1) / 64'd2)
	};
	localparam int unsigned COS_SH [COS_STEPS] = '{38, 37, 36, 35, 34, 31};

	typedef logic signed [31:0] q30_t;
	typedef logic [1:0] corner_t;

	localparam corner_t CORNER_UL = 2'd0;
	localparam corner_t CORNER_LL = 2'd1;
	localparam corner_t CORNER_UR = 2'd2;
	localparam corner_t CORNER_LR = 2'd3;

	localparam logic REG_LAT = 1'b0;
	localparam logic REG_LON = 1'b1;

	typedef struct packed {
		logic [DIV_W-1:0] num;
		logic [REM_W-1:0] rem;
	} div_t;

	typedef struct packed {
		corner_t     corner;
		logic [18:0] vidx;
		logic        bad;
		logic        last;
	} side_t;

	function automatic div_t div_step(div_t a, logic [REM_W-1:0] d);
		div_t       r;
		logic [REM_W:0] t;
		r = a;
		for (int i = 0; i < DIV_BITS; i++) begin
			t = {r.rem, r.num[DIV_W-1]};
			r.num = {r.num[DIV_W-2:0], 1'b0};
			if (t >= {1'b0, d}) begin
				t = t - {1'b0, d};
				r.num[0] = 1'b1;
			end
			r.rem = t[REM_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### design/uv_sphere_patch_generator_core.sv
// channel | dir | handshake            | payload
// in      | in  | in_valid / in_ready  | row, col
// out     | out | out_valid / out_ready| pos_x/y/z, tex_u/v, corner, vertex_index,
//         |     |                      | bad_index, last
// cfg     | in  | cfg_we               | cfg_idx, cfg_wdata
//
// Each request expands into four vertices, one per cycle unless the output stalls;
// the next request is taken with the last corner. 6 long-division stages (8 bits
// each) and a 15-stage sine/cosine Horner pipeline set the depth.
// Reset clears the valid bits and the corner sequencer; both segment registers load 10.
// out_ready low freezes the pipe while out_valid; an idle core still takes requests.
`default_nettype none

module uv_sphere_patch_generator_core (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [8:0]                row,
	input  wire logic [7:0]                col,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic signed [15:0]             pos_x,
	output logic signed [15:0]             pos_y,
	output logic signed [15:0]             pos_z,
	output logic [16:0]                    tex_u,
	output logic [16:0]                    tex_v,
	output uvs_pkg::corner_t               corner,
	output logic [18:0]                    vertex_index,
	output logic                           bad_index,
	output logic                           last,
	input  wire logic                      cfg_we,
	input  wire logic                      cfg_idx,
	input  wire logic [uvs_pkg::SEG_W-1:0] cfg_wdata
);
	import uvs_pkg::*;

	localparam int unsigned NSTG     = 25;
	localparam int unsigned DV_LAT   = 0;
	localparam int unsigned DV_LON   = 1;
	localparam int unsigned DV_U     = 2;
	localparam int unsigned DV_V     = 3;
	localparam int unsigned RND_SH   = 60 - FRAC_BITS;
	localparam logic signed [63:0] RND_HALF = 64'sd1 <<< (RND_SH - 1);

	function automatic logic [SEG_W-1:0] eff_seg(logic [SEG_W-1:0] v);
		if (v == '0) begin
			return SEG_W'(1);
		end else if (v > SEG_W'(MAX_SEGMENTS)) begin
			return SEG_W'(MAX_SEGMENTS);
		end
		return v;
	endfunction

	function automatic logic [16:0] tex_sat(logic [DIV_W-1:0] q);
		return (q > DIV_W'(65536)) ? 17'd65536 : q[16:0];
	endfunction

	function automatic logic [15:0] q60_round(logic signed [63:0] v);
		logic signed [63:0] t;
		t = v + (v[63] ? (RND_HALF - 64'sd1) : RND_HALF);
		return 16'(t >>> RND_SH);
	endfunction

	logic [SEG_W-1:0] lat_q;
	logic [SEG_W-1:0] lon_q;
	logic [8:0]       row_q;
	logic [7:0]       col_q;
	logic             hv_q;
	corner_t          k_q;

	logic [NSTG:1]    v_s;
	side_t            side_s [1:NSTG];
	div_t             dv_s   [1:DIV_STAGES+1][4];
	logic [31:0]      plat_s8;
	logic [31:0]      plon_s8;
	logic [16:0]      tu_s   [8:NSTG];
	logic [16:0]      tv_s   [8:NSTG];
	logic signed [63:0] prx_s24;
	logic signed [63:0] pry_s24;
	logic signed [63:0] prz_s24;
	logic [15:0]      px_s25;
	logic [15:0]      py_s25;
	logic [15:0]      pz_s25;

	logic [SEG_W-1:0] lat_e;
	logic [SEG_W-1:0] lon_e;
	logic [REM_W-1:0] den [4];
	logic             adv;
	logic             accept;
	logic [9:0]       re;
	logic [8:0]       ce;
	logic [18:0]      lin;
	q30_t             sl;
	q30_t             cl;
	q30_t             so;
	q30_t             co;

	assign lat_e  = eff_seg(lat_q);
	assign lon_e  = eff_seg(lon_q);
	assign adv    = !v_s[NSTG] || out_ready;
	assign in_ready = !hv_q || (k_q == CORNER_LR && adv);
	assign accept = in_valid && in_ready;

	always_comb begin
		den[DV_LAT] = REM_W'(lat_e);
		den[DV_LON] = REM_W'(lon_e);
		den[DV_U]   = REM_W'(lon_e);
		den[DV_V]   = {lat_e, 1'b0};
		re  = 10'(row_q) + ((k_q == CORNER_UL || k_q == CORNER_UR) ? 10'd1 : 10'd0);
		ce  = 9'(col_q) + ((k_q == CORNER_UR || k_q == CORNER_LR) ? 9'd1 : 9'd0);
		lin = 19'(18'(row_q) * 18'(lon_e)) + 19'(col_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_q <= SEG_W'(10);
			lon_q <= SEG_W'(10);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_LAT: lat_q <= cfg_wdata;
				REG_LON: lon_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_q <= 1'b0;
			k_q  <= CORNER_UL;
			v_s  <= '0;
		end else begin
			if (accept) begin
				hv_q <= 1'b1;
				k_q  <= CORNER_UL;
			end else if (hv_q && adv) begin
				k_q <= k_q + 2'd1;
				if (k_q == CORNER_LR) begin
					hv_q <= 1'b0;
				end
			end
			if (adv) begin
				v_s <= {v_s[NSTG-1:1], hv_q};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_q <= row;
			col_q <= col;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[1].corner <= k_q;
			side_s[1].vidx   <= 19'({lin, k_q});
			side_s[1].bad    <= (10'(row_q) >= {lat_e, 1'b0}) || (9'(col_q) >= lon_e);
			side_s[1].last   <= (k_q == CORNER_LR);
			for (int k = 2; k <= NSTG; k++) begin
				side_s[k] <= side_s[k-1];
			end

			dv_s[1][DV_LAT] <= '{num: (DIV_W'(re) << 30) + DIV_W'(lat_e >> 1), rem: '0};
			dv_s[1][DV_LON] <= '{num: (DIV_W'(ce) << 32) + DIV_W'(lon_e >> 1), rem: '0};
			dv_s[1][DV_U]   <= '{num: (DIV_W'(ce) << 16) + DIV_W'(lon_e >> 1), rem: '0};
			dv_s[1][DV_V]   <= '{num: (DIV_W'(re) << 16) + DIV_W'(lat_e), rem: '0};
			for (int k = 2; k <= DIV_STAGES + 1; k++) begin
				for (int u = 0; u < 4; u++) begin
					dv_s[k][u] <= div_step(dv_s[k-1][u], den[u]);
				end
			end

			plat_s8 <= dv_s[DIV_STAGES+1][DV_LAT].num[31:0] - 32'h4000_0000;
			plon_s8 <= dv_s[DIV_STAGES+1][DV_LON].num[31:0];
			tu_s[8] <= tex_sat(dv_s[DIV_STAGES+1][DV_U].num);
			tv_s[8] <= tex_sat(dv_s[DIV_STAGES+1][DV_V].num);
			for (int k = 9; k <= NSTG; k++) begin
				tu_s[k] <= tu_s[k-1];
				tv_s[k] <= tv_s[k-1];
			end

			prx_s24 <= 64'(cl) * 64'(co);
			prz_s24 <= 64'(cl) * 64'(so);
			pry_s24 <= 64'(sl) <<< 30;
			px_s25  <= q60_round(prx_s24);
			py_s25  <= q60_round(pry_s24);
			pz_s25  <= q60_round(prz_s24);
		end
	end

	uvs_sincos u_lat (
		.clk   (clk),
		.en    (adv),
		.phase (plat_s8),
		.sn    (sl),
		.cs    (cl)
	);

	uvs_sincos u_lon (
		.clk   (clk),
		.en    (adv),
		.phase (plon_s8),
		.sn    (so),
		.cs    (co)
	);

	assign out_valid    = v_s[NSTG];
	assign pos_x        = px_s25;
	assign pos_y        = py_s25;
	assign pos_z        = pz_s25;
	assign tex_u        = tu_s[NSTG];
	assign tex_v        = tv_s[NSTG];
	assign corner       = side_s[NSTG].corner;
	assign vertex_index = side_s[NSTG].vidx;
	assign bad_index    = side_s[NSTG].bad;
	assign last         = side_s[NSTG].last;

	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (corner == CORNER_LR)))
		else $error("last flag out of step with corner");

	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (hv_q && k_q == CORNER_UL))
		else $error("request not loaded at first corner");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(hv_q && adv && k_q != CORNER_LR) |=> hv_q)
		else $error("request dropped before fourth corner");

	a_tex: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (tex_u <= 17'd65536 && tex_v <= 17'd65536))
		else $error("texture coordinate above one");

endmodule

`default_nettype wire

### design/uvs_sincos.sv
`default_nettype none

module uvs_sincos (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire logic [uvs_pkg::PHASE_W-1:0] phase,
	output uvs_pkg::q30_t                    sn,
	output uvs_pkg::q30_t                    cs
);
	import uvs_pkg::*;

	localparam logic [1:0] QUAD_I   = 2'd0;
	localparam logic [1:0] QUAD_II  = 2'd1;
	localparam logic [1:0] QUAD_III = 2'd2;
	localparam logic [1:0] QUAD_IV  = 2'd3;

	logic [29:0] g_s1;
	logic [1:0]  quad_s [1:14];
	logic        swap_s [1:14];
	logic [29:0] x_s    [2:12];
	logic [29:0] x2_s   [3:12];
	logic [30:0] ch_s   [COS_STEPS];
	logic [29:0] cn_s   [1:COS_STEPS-1];
	logic [30:0] sh_s   [SIN_STEPS];
	logic [29:0] sn_p_s [1:SIN_STEPS-1];
	logic [30:0] s_s13;
	logic [30:0] s_s14;
	q30_t        sn_s15;
	q30_t        cs_s15;

	logic [29:0] f;
	logic        swap;
	logic [30:0] gw;
	logic [60:0] pg;
	logic [60:0] pxx;
	logic [60:0] ps;
	logic [29:0] cnin [COS_STEPS];
	logic [29:0] snin [SIN_STEPS];
	logic [60:0] cb_p [COS_STEPS];
	logic [60:0] sb_p [SIN_STEPS];
	logic [60:0] ca_p [1:COS_STEPS-1];
	logic [60:0] sa_p [1:SIN_STEPS-1];
	logic [30:0] s0;
	logic [30:0] c0;
	q30_t        sn_d;
	q30_t        cs_d;

	// reduce to [0, pi/4] of a quadrant
	always_comb begin
		f    = phase[29:0];
		swap = f > QUAD_HALF;
		gw   = Q30_ONE - {1'b0, f};
		pg   = 61'(g_s1) * 61'(HALF_PI_Q30) + 61'(QUAD_HALF);
		pxx  = 61'(x_s[2]) * 61'(x_s[2]) + 61'(QUAD_HALF);
		ps   = 61'(x_s[12]) * 61'(sh_s[SIN_STEPS-1]);
	end

	always_comb begin
		cnin[0] = x2_s[3];
		for (int j = 1; j < COS_STEPS; j++) begin
			cnin[j] = cn_s[j];
		end
		for (int j = 0; j < COS_STEPS; j++) begin
			cb_p[j] = (61'(cnin[j]) * 61'(COS_RCP[j])) >> COS_SH[j];
		end
		for (int j = 1; j < COS_STEPS; j++) begin
			ca_p[j] = 61'(x2_s[2+2*j]) * 61'(ch_s[j-1]);
		end
		snin[0] = x2_s[3];
		for (int j = 1; j < SIN_STEPS; j++) begin
			snin[j] = sn_p_s[j];
		end
		for (int j = 0; j < SIN_STEPS; j++) begin
			sb_p[j] = (61'(snin[j]) * 61'(SIN_RCP[j])) >> SIN_SH[j];
		end
		for (int j = 1; j < SIN_STEPS; j++) begin
			sa_p[j] = 61'(x2_s[2+2*j]) * 61'(sh_s[j-1]);
		end
	end

	always_comb begin
		s0 = swap_s[14] ? ch_s[COS_STEPS-1] : s_s14;
		c0 = swap_s[14] ? s_s14 : ch_s[COS_STEPS-1];
		unique case (quad_s[14])
			QUAD_I: begin
				sn_d = q30_t'({1'b0, s0});
				cs_d = q30_t'({1'b0, c0});
			end
			QUAD_II: begin
				sn_d = q30_t'({1'b0, c0});
				cs_d = -q30_t'({1'b0, s0});
			end
			QUAD_III: begin
				sn_d = -q30_t'({1'b0, s0});
				cs_d = -q30_t'({1'b0, c0});
			end
			QUAD_IV: begin
				sn_d = -q30_t'({1'b0, c0});
				cs_d = q30_t'({1'b0, s0});
			end
			default: begin
				sn_d = '0;
				cs_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_s1      <= swap ? gw[29:0] : f;
			quad_s[1] <= phase[31:30];
			swap_s[1] <= swap;
			for (int k = 2; k <= 14; k++) begin
				quad_s[k] <= quad_s[k-1];
				swap_s[k] <= swap_s[k-1];
			end
			x_s[2] <= pg[59:30];
			for (int k = 3; k <= 12; k++) begin
				x_s[k] <= x_s[k-1];
			end
			x2_s[3] <= pxx[59:30];
			for (int k = 4; k <= 12; k++) begin
				x2_s[k] <= x2_s[k-1];
			end
			for (int j = 0; j < COS_STEPS; j++) begin
				ch_s[j] <= Q30_ONE - 31'(cb_p[j]);
			end
			for (int j = 1; j < COS_STEPS; j++) begin
				cn_s[j] <= ca_p[j][59:30];
			end
			for (int j = 0; j < SIN_STEPS; j++) begin
				sh_s[j] <= Q30_ONE - 31'(sb_p[j]);
			end
			for (int j = 1; j < SIN_STEPS; j++) begin
				sn_p_s[j] <= sa_p[j][59:30];
			end
			s_s13  <= {1'b0, ps[59:30]};
			s_s14  <= s_s13;
			sn_s15 <= sn_d;
			cs_s15 <= cs_d;
		end
	end

	assign sn = sn_s15;
	assign cs = cs_s15;

endmodule

`default_nettype wire
